// ----- sv/sm4_pkg.sv -----
// sm4_pkg: shared types, constants and round functions of the sm4 block cipher
// s-box table, fk and ck key constants, linear maps l and l'
// no dependencies
package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_IDX_W    = $clog2(ROUND_COUNT);

    typedef logic [31:0]  t_word;
    typedef logic [127:0] t_block;
    typedef logic [ROUND_COUNT-1:0][31:0] t_rk_arr;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_KEY_HIGH     = 2'd0;
    localparam t_cfg_idx CFG_KEY_LOW      = 2'd1;
    localparam t_cfg_idx CFG_DECRYPT_MODE = 2'd2;

    // key expansion sequencer states
    typedef enum logic [1:0] {
        KS_LOAD,
        KS_RUN,
        KS_DONE
    } t_ks_state;

    localparam t_word FK0 = 32'ha3b1bac6;
    localparam t_word FK1 = 32'h56aa3350;
    localparam t_word FK2 = 32'h677d9197;
    localparam t_word FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // byte-wise s-box substitution
    function automatic t_word tau(input t_word a);
        tau = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
    endfunction

    // data path transform: s-box then l
    function automatic t_word data_t(input t_word a);
        t_word b;
        b = tau(a);
        data_t = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // key path transform: s-box then l'
    function automatic t_word key_t(input t_word a);
        t_word b;
        b = tau(a);
        key_t = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // ck constant: byte j of word i is (4i+j)*7 mod 256
    function automatic t_word ck_word(input logic [RK_IDX_W-1:0] i);
        t_word      w;
        logic [7:0] n;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            n = {i, 2'(j)} & 8'hff;
            w = {w[23:0], 8'(n * 8'd7)};
        end
        ck_word = w;
    endfunction

endpackage

// ----- sv/sm4_round.sv -----
// sm4_cipher_stage: one registered cipher round of the sm4 data pipeline
// depends on sm4_pkg for the round transform
module sm4_cipher_stage
    import sm4_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_block i_x,
    input  logic   i_last,
    input  t_word  i_rk,
    output logic   o_vld,
    output t_block o_x,
    output logic   o_last
);

    logic   r_vld;
    t_block r_x;
    logic   r_last;
    t_word  n_word;

    // new word from x0 and the transform of x1^x2^x3^rk
    assign n_word = i_x[127:96] ^ data_t(i_x[95:64] ^ i_x[63:32] ^ i_x[31:0] ^ i_rk);

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    // word shift with the new word entering at the bottom
    always_ff @(posedge i_clk) begin
        r_x    <= {i_x[95:0], n_word};
        r_last <= i_last;
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_last = r_last;

endmodule

// ----- sv/sm4_key_sched.sv -----
// sm4_key_sched: configuration registers and iterative round key expansion
// one key round per cycle into a register file; depends on sm4_pkg
module sm4_key_sched
    import sm4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_ready,
    output t_rk_arr     o_rk
);

    localparam logic [RK_IDX_W-1:0] LAST_IDX = RK_IDX_W'(ROUND_COUNT - 1);

    logic [63:0]         r_key_high;
    logic [63:0]         r_key_low;
    logic                r_dec;
    t_ks_state           r_state;
    t_ks_state           n_state;
    logic [RK_IDX_W-1:0] r_cnt;
    t_word               r_k [4];
    t_word               r_rk [ROUND_COUNT];
    t_word               n_key;
    logic [RK_IDX_W-1:0] n_wr_idx;
    logic                n_cfg_hit;

    assign n_cfg_hit = i_cfg_we && (i_cfg_index == CFG_KEY_HIGH ||
                                    i_cfg_index == CFG_KEY_LOW  ||
                                    i_cfg_index == CFG_DECRYPT_MODE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_dec      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_HIGH:     r_key_high <= i_cfg_data;
                CFG_KEY_LOW:      r_key_low  <= i_cfg_data;
                CFG_DECRYPT_MODE: r_dec      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state: any key write restarts the expansion
    always_comb begin
        n_state = r_state;
        case (r_state)
            KS_LOAD: n_state = KS_RUN;
            KS_RUN:  if (r_cnt == LAST_IDX) n_state = KS_DONE;
            KS_DONE: n_state = KS_DONE;
            default: n_state = KS_LOAD;
        endcase
        if (n_cfg_hit) begin
            n_state = KS_LOAD;
        end
    end

    // one key round and its store address
    assign n_key    = r_k[0] ^ key_t(r_k[1] ^ r_k[2] ^ r_k[3] ^ ck_word(r_cnt));
    assign n_wr_idx = r_dec ? (LAST_IDX - r_cnt) : r_cnt;

    // key word shift and round counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == KS_LOAD) begin
            r_cnt <= '0;
        end else if (r_state == KS_RUN) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == KS_LOAD) begin
            r_k[0] <= r_key_high[63:32] ^ FK0;
            r_k[1] <= r_key_high[31:0]  ^ FK1;
            r_k[2] <= r_key_low[63:32]  ^ FK2;
            r_k[3] <= r_key_low[31:0]   ^ FK3;
        end else if (r_state == KS_RUN) begin
            r_k[0] <= r_k[1];
            r_k[1] <= r_k[2];
            r_k[2] <= r_k[3];
            r_k[3] <= n_key;
        end
    end

    // round key store, forward or reversed order
    always_ff @(posedge i_clk) begin
        if (r_state == KS_RUN) begin
            r_rk[n_wr_idx] <= n_key;
        end
    end

    always_comb begin
        for (int i = 0; i < ROUND_COUNT; i++) begin
            o_rk[i] = r_rk[i];
        end
    end

    assign o_ready = (r_state == KS_DONE);

    // a key write always forces a fresh expansion
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_cfg_hit |=> (r_state == KS_LOAD))
        else $error("key write did not restart expansion");

    // load is followed by the first key round
    a_load_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KS_LOAD && !n_cfg_hit) |=> (r_state == KS_RUN && r_cnt == '0))
        else $error("expansion did not start at round zero");

    // the final key round ends in the ready state
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == KS_RUN && r_cnt == LAST_IDX && !n_cfg_hit) |=> o_ready)
        else $error("expansion did not finish after the last round");

endmodule

// ----- sv/sm4_block_cipher_unit.sv -----
// sm4_block_cipher_unit: top level of the pipelined sm4 cipher
// input register, one sm4_cipher_stage per round, sm4_key_sched; uses sm4_pkg
// a word captured in the input register passes through every round stage to the result ports
// throughput: one word per cycle once round keys are ready; results cannot be stalled
// after reset or any key write, o_busy stays high while the key
// sequencer loads and runs its 32 key rounds
module sm4_block_cipher_unit
    import sm4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic        i_last_block,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low,
    output logic        o_out_last
);

    logic    ks_ready;
    t_rk_arr ks_rk;
    logic    r_in_vld;
    t_block  r_in_x;
    logic    r_in_last;
    logic    s_vld  [ROUND_COUNT+1];
    t_block  s_x    [ROUND_COUNT+1];
    logic    s_last [ROUND_COUNT+1];
    t_block  n_x;

    sm4_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ready     (ks_ready),
        .o_rk        (ks_rk)
    );

    assign o_busy = !ks_ready;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && ks_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_x    <= {i_block_high, i_block_low};
        r_in_last <= i_last_block;
    end

    assign s_vld[0]  = r_in_vld;
    assign s_x[0]    = r_in_x;
    assign s_last[0] = r_in_last;

    // round pipeline
    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        sm4_cipher_stage u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (s_vld[g]),
            .i_x     (s_x[g]),
            .i_last  (s_last[g]),
            .i_rk    (ks_rk[g]),
            .o_vld   (s_vld[g+1]),
            .o_x     (s_x[g+1]),
            .o_last  (s_last[g+1])
        );
    end

    // result word with its words in reverse order
    assign n_x        = s_x[ROUND_COUNT];
    assign o_valid    = s_vld[ROUND_COUNT];
    assign o_out_high = {n_x[31:0], n_x[63:32]};
    assign o_out_low  = {n_x[95:64], n_x[127:96]};
    assign o_out_last = s_last[ROUND_COUNT];

endmodule
